// File: hw/rtl/efd_pkg.sv
// efd_pkg.sv - shared constants, types and state encodings for the escaped frame deframer.
// Used by every module under hw/rtl except efd_ram; depends on nothing.
package efd_pkg;

    localparam int BUF_LEN_DEF  = 512;
    localparam int MAX_DATA_DEF = 223;

    localparam logic [7:0] DLE_CODE  = 8'h10;
    localparam logic [7:0] STX_CODE  = 8'h02;
    localparam logic [7:0] ETX_CODE  = 8'h03;
    localparam logic [7:0] TYPE_CODE = 8'h93;

    localparam int HDR_LEN     = 13;
    localparam int HDR_AW      = 4;
    localparam int MIN_DECL    = 12;
    localparam int PAYLOAD_OFS = 13;
    localparam int PAYLOAD_MAX = 256;

    localparam int NUM_BANKS  = 2;
    localparam int BANK_W     = 1;
    localparam int WORD_AW    = 5;
    localparam int RAM_AW     = BANK_W + WORD_AW;
    localparam int RAM_DEPTH  = NUM_BANKS * (1 << WORD_AW);
    localparam int WORD_W     = 64;
    localparam int QUEUE_DEPTH = NUM_BANKS;

    typedef struct packed {
        logic [7:0]         priority_res;
        logic [23:0]        group_number;
        logic [7:0]         destination;
        logic [7:0]         source;
        logic [31:0]        timestamp;
        logic [7:0]         payload_length;
        logic [7:0]         limit;
        logic [WORD_AW-1:0] last_index;
        logic [BANK_W-1:0]  bank;
    } desc_t;

    typedef enum logic [1:0] {
        BK_FETCH,
        BK_LOAD,
        BK_SHOW
    } back_state_t;

endpackage

// File: hw/rtl/efd_ram.sv
// efd_ram.sv - generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module efd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/efd_front.sv
// efd_front.sv - byte-level deframer: escape handling, header capture, checksum, frame checks.
// Packs payload bytes into 64-bit words for the payload RAM; pushes a descriptor per good frame.
// Depends on efd_pkg.
module efd_front #(
    parameter int BUF_LEN  = efd_pkg::BUF_LEN_DEF,
    parameter int MAX_DATA = efd_pkg::MAX_DATA_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 rx_byte,
    input  logic                       q_full,
    output logic                       q_push,
    output efd_pkg::desc_t             q_desc,
    output logic                       ram_we,
    output logic [efd_pkg::RAM_AW-1:0] ram_waddr,
    output logic [efd_pkg::WORD_W-1:0] ram_wdata
);

    localparam int WP_W = $clog2(BUF_LEN + 1);

    logic            in_frame_reg, in_frame_next;
    logic            esc_reg, esc_next;
    logic            start_reg, start_next;
    logic [WP_W-1:0] wp_reg, wp_next;
    logic [7:0]      sum_reg, sum_next;
    logic [7:0]      last_byte_reg;
    logic [7:0]      hdr_reg [0:efd_pkg::HDR_LEN-1];
    logic [efd_pkg::WORD_W-1:0] acc_reg;
    logic [efd_pkg::BANK_W-1:0] wbank_reg;

    logic            fire;
    logic            do_store;
    logic            store_ok;
    logic            do_drop;
    logic            do_finish;
    logic            restart;
    logic            accept;
    logic [WP_W-1:0] decl_ext;
    logic [WP_W-1:0] pidx;
    logic [WP_W-1:0] flush_idx;
    logic            in_payload;
    logic            word_done;
    logic [7:0]      avail;
    logic [7:0]      plen_m1;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign decl_ext = WP_W'(hdr_reg[1]);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        start_next    = start_reg;
        wp_next       = wp_reg;
        sum_next      = sum_reg;
        do_store      = 1'b0;
        do_drop       = 1'b0;
        do_finish     = 1'b0;
        restart       = 1'b0;
        if (fire)
        begin
            if (in_frame_reg)
            begin
                if (esc_reg)
                begin
                    priority if (rx_byte == efd_pkg::DLE_CODE)
                    begin
                        esc_next = 1'b0;
                        do_store = 1'b1;
                    end
                    else if (rx_byte == efd_pkg::ETX_CODE)
                    begin
                        do_finish = 1'b1;
                        do_drop   = 1'b1;
                    end
                    else if (rx_byte == efd_pkg::STX_CODE)
                    begin
                        do_drop = 1'b1;
                        restart = 1'b1;
                    end
                    else
                    begin
                        do_drop = 1'b1;
                    end
                end
                else if (rx_byte == efd_pkg::DLE_CODE)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    do_store = 1'b1;
                end
            end
            else
            begin
                if (rx_byte == efd_pkg::STX_CODE)
                begin
                    start_next = esc_reg;
                end
                else if (start_reg)
                begin
                    start_next    = 1'b0;
                    in_frame_next = 1'b1;
                    do_store      = 1'b1;
                end
                esc_next = (rx_byte == efd_pkg::DLE_CODE);
            end
        end
        store_ok = do_store && (wp_reg != WP_W'(BUF_LEN));
        if (do_store && !store_ok)
        begin
            do_drop = 1'b1;
        end
        if (store_ok)
        begin
            wp_next = wp_reg + WP_W'(1);
            // checksum byte sits at offset length + 2 and stays out of the sum
            if (wp_reg != decl_ext + WP_W'(2))
            begin
                sum_next = sum_reg + rx_byte;
            end
        end
        if (do_drop)
        begin
            wp_next       = '0;
            sum_next      = '0;
            in_frame_next = 1'b0;
            esc_next      = 1'b0;
            start_next    = restart;
        end
    end

    assign accept = do_finish
                 && (wp_reg == decl_ext + WP_W'(3))
                 && (hdr_reg[0] == efd_pkg::TYPE_CODE)
                 && (hdr_reg[1] >= 8'(efd_pkg::MIN_DECL))
                 && (8'(sum_reg + last_byte_reg) == 8'h00)
                 && (hdr_reg[12] <= 8'(MAX_DATA));

    assign pidx       = wp_reg - WP_W'(efd_pkg::PAYLOAD_OFS);
    assign flush_idx  = wp_reg - WP_W'(efd_pkg::PAYLOAD_OFS + 1);
    assign in_payload = (wp_reg >= WP_W'(efd_pkg::PAYLOAD_OFS))
                     && (wp_reg < WP_W'(efd_pkg::PAYLOAD_OFS + efd_pkg::PAYLOAD_MAX));
    assign word_done  = store_ok && in_payload && (pidx[2:0] == 3'd7);

    always_comb
    begin
        ram_we    = word_done || accept;
        ram_waddr = {wbank_reg, flush_idx[7:3]};
        ram_wdata = acc_reg;
        if (word_done)
        begin
            ram_waddr = {wbank_reg, pidx[7:3]};
            ram_wdata = {rx_byte, acc_reg[55:0]};
        end
    end

    assign avail   = hdr_reg[1] - 8'd11;
    assign plen_m1 = hdr_reg[12] - 8'd1;

    always_comb
    begin
        q_push                = accept;
        q_desc.priority_res   = hdr_reg[2];
        q_desc.group_number   = {hdr_reg[5], hdr_reg[4], hdr_reg[3]};
        q_desc.destination    = hdr_reg[6];
        q_desc.source         = hdr_reg[7];
        q_desc.timestamp      = {hdr_reg[11], hdr_reg[10], hdr_reg[9], hdr_reg[8]};
        q_desc.payload_length = hdr_reg[12];
        q_desc.limit          = (hdr_reg[12] < avail) ? hdr_reg[12] : avail;
        q_desc.last_index     = (hdr_reg[12] == 8'd0) ? '0 : plen_m1[7:3];
        q_desc.bank           = wbank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            start_reg    <= 1'b0;
            wp_reg       <= '0;
            sum_reg      <= '0;
            wbank_reg    <= '0;
            for (int i = 0; i < efd_pkg::HDR_LEN; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            start_reg    <= start_next;
            wp_reg       <= wp_next;
            sum_reg      <= sum_next;
            if (accept)
            begin
                wbank_reg <= wbank_reg + efd_pkg::BANK_W'(1);
            end
            if (store_ok && (wp_reg < WP_W'(efd_pkg::HDR_LEN)))
            begin
                hdr_reg[wp_reg[efd_pkg::HDR_AW-1:0]] <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_ok)
        begin
            last_byte_reg <= rx_byte;
            if (in_payload)
            begin
                acc_reg[pidx[2:0]*8 +: 8] <= rx_byte;
            end
        end
    end

endmodule

// File: hw/rtl/efd_desc_fifo.sv
// efd_desc_fifo.sv - two-entry queue of frame descriptors between front and back.
// Depends on efd_pkg.
module efd_desc_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  efd_pkg::desc_t push_desc,
    input  logic           pop,
    output efd_pkg::desc_t head,
    output logic           full,
    output logic           empty
);

    localparam int PW = $clog2(efd_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(efd_pkg::QUEUE_DEPTH + 1);

    efd_pkg::desc_t ent_reg [0:efd_pkg::QUEUE_DEPTH-1];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg, count_next;

    assign full  = (count_reg == CW'(efd_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("descriptor pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("descriptor popped from empty queue");

endmodule

// File: hw/rtl/efd_back.sv
// efd_back.sv - chunk sequencer: reads payload words for the head descriptor, masks, presents.
// Depends on efd_pkg.
module efd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  efd_pkg::desc_t              head,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        ram_re,
    output logic [efd_pkg::RAM_AW-1:0]  ram_raddr,
    input  logic [efd_pkg::WORD_W-1:0]  ram_rdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [efd_pkg::WORD_AW-1:0] chunk_index,
    output logic [efd_pkg::WORD_W-1:0]  chunk_data,
    output logic                        last_chunk
);

    efd_pkg::back_state_t state_reg, state_next;
    logic [efd_pkg::WORD_AW-1:0] k_reg, k_next;
    logic [efd_pkg::WORD_W-1:0]  data_reg;
    logic [efd_pkg::WORD_W-1:0]  masked;
    logic                        last_reg;
    logic                        load;
    logic [7:0]                  j;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ram_re     = 1'b0;
        q_pop      = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            efd_pkg::BK_FETCH:
            begin
                if (!q_empty)
                begin
                    ram_re     = 1'b1;
                    state_next = efd_pkg::BK_LOAD;
                end
            end
            efd_pkg::BK_LOAD:
            begin
                load       = 1'b1;
                state_next = efd_pkg::BK_SHOW;
            end
            efd_pkg::BK_SHOW:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        q_pop  = 1'b1;
                        k_next = '0;
                    end
                    else
                    begin
                        k_next = k_reg + efd_pkg::WORD_AW'(1);
                    end
                    state_next = efd_pkg::BK_FETCH;
                end
            end
            default:
            begin
                state_next = efd_pkg::BK_FETCH;
            end
        endcase
    end

    assign ram_raddr = {head.bank, k_reg};

    // bytes at or past min(payload length, bytes before checksum) read as zero
    always_comb
    begin
        masked = '0;
        j      = '0;
        for (int i = 0; i < 8; i++)
        begin
            j = {k_reg, 3'(i)};
            masked[i*8 +: 8] = (j < head.limit) ? ram_rdata[i*8 +: 8] : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= efd_pkg::BK_FETCH;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= masked;
            last_reg <= (k_reg == head.last_index);
        end
    end

    assign out_valid   = (state_reg == efd_pkg::BK_SHOW);
    assign chunk_index = k_reg;
    assign chunk_data  = data_reg;
    assign last_chunk  = last_reg;

    a_show_has_desc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != efd_pkg::BK_FETCH) |-> !q_empty)
        else $error("chunk in flight without a descriptor");

    a_last_resets_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_chunk) |=> (k_reg == '0))
        else $error("chunk index not cleared after last chunk");

endmodule

// File: hw/rtl/escaped_frame_deframer.sv
// escaped_frame_deframer.sv - top level: front deframer, descriptor queue, payload RAM, back.
// Input: one byte per cycle; in_ready drops only while two accepted frames await readout.
// First chunk: DLE-ETX transfer queues its descriptor; an idle back then does fetch, load, show.
// Readout: each chunk is a RAM read, mask/register, present; next fetch waits until it is taken.
// Reset: asynchronous rst_n clears framing state, queue and sequencer; RAM is not cleared.
module escaped_frame_deframer #(
    parameter int BUF_LEN  = efd_pkg::BUF_LEN_DEF,
    parameter int MAX_DATA = efd_pkg::MAX_DATA_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  priority_res,
    output logic [23:0]                 group_number,
    output logic [7:0]                  destination,
    output logic [7:0]                  source,
    output logic [31:0]                 timestamp,
    output logic [7:0]                  payload_length,
    output logic [efd_pkg::WORD_AW-1:0] chunk_index,
    output logic [efd_pkg::WORD_W-1:0]  chunk_data,
    output logic                        last_chunk
);

    logic                        q_full;
    logic                        q_empty;
    logic                        q_push;
    logic                        q_pop;
    efd_pkg::desc_t              q_desc;
    efd_pkg::desc_t              q_head;
    logic                        ram_we;
    logic [efd_pkg::RAM_AW-1:0]  ram_waddr;
    logic [efd_pkg::WORD_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [efd_pkg::RAM_AW-1:0]  ram_raddr;
    logic [efd_pkg::WORD_W-1:0]  ram_rdata;

    efd_front #(
        .BUF_LEN  (BUF_LEN),
        .MAX_DATA (MAX_DATA)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (q_desc),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    efd_desc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_desc),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    efd_ram #(
        .WIDTH (efd_pkg::WORD_W),
        .DEPTH (efd_pkg::RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    efd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .chunk_index (chunk_index),
        .chunk_data  (chunk_data),
        .last_chunk  (last_chunk)
    );

    assign priority_res   = q_head.priority_res;
    assign group_number   = q_head.group_number;
    assign destination    = q_head.destination;
    assign source         = q_head.source;
    assign timestamp      = q_head.timestamp;
    assign payload_length = q_head.payload_length;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// testbench.sv - self-checking bench for escaped_frame_deframer: DLE-framed byte streams in,
// header plus eight-byte payload chunks out, checked against a built-in deframer predictor.
// Depends on efd_pkg and the escaped_frame_deframer RTL only.
module testbench;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0]                  priority_res;
        logic [23:0]                 group_number;
        logic [7:0]                  destination;
        logic [7:0]                  source;
        logic [31:0]                 timestamp;
        logic [7:0]                  payload_length;
        logic [efd_pkg::WORD_AW-1:0] chunk_index;
        logic [efd_pkg::WORD_W-1:0]  chunk_data;
        logic                        last_chunk;
    } chunk_t;

    typedef enum int {
        END_ETX,
        END_ABORT,
        END_RESTART,
        END_OPEN
    } frame_end_t;

    class frame_checker;
        logic [7:0]  frame_mem [efd_pkg::BUF_LEN_DEF];
        int unsigned wr_pos;
        logic [7:0]  byte_sum;
        bit          in_frame;
        bit          esc_pending;
        bit          start_seen;
        chunk_t      pending[$];
        int          errors;
        int          chunks_due;

        function new();
            foreach (frame_mem[i])
                frame_mem[i] = 8'h00;
            drop_frame();
            errors = 0;
            chunks_due = 0;
        endfunction

        function void drop_frame();
            wr_pos = 0;
            byte_sum = 8'h00;
            in_frame = 1'b0;
            esc_pending = 1'b0;
            start_seen = 1'b0;
        endfunction

        function bit store_byte(logic [7:0] b);
            if (wr_pos >= efd_pkg::BUF_LEN_DEF)
                return 1'b0;
            frame_mem[wr_pos] = b;
            wr_pos++;
            // checksum byte sits at declared length + 2 and is left out of the sum
            if (int'(frame_mem[1]) + 3 != wr_pos)
                byte_sum = byte_sum + b;
            return 1'b1;
        endfunction

        function void close_frame();
            int unsigned decl;
            int unsigned plen;
            int unsigned avail;
            int unsigned nchunks;
            int unsigned j;
            chunk_t c;
            if (wr_pos < 1 || frame_mem[0] != efd_pkg::TYPE_CODE)
                return;
            decl = frame_mem[1];
            if (decl < efd_pkg::MIN_DECL || wr_pos != decl + 3)
                return;
            if (8'(byte_sum + frame_mem[wr_pos - 1]) != 8'h00)
                return;
            plen = frame_mem[12];
            if (plen > efd_pkg::MAX_DATA_DEF)
                return;
            avail = wr_pos - 14;
            nchunks = (plen + 7) / 8;
            if (nchunks == 0)
                nchunks = 1;
            for (int k = 0; k < nchunks; k++)
            begin
                c.priority_res   = frame_mem[2];
                c.group_number   = {frame_mem[5], frame_mem[4], frame_mem[3]};
                c.destination    = frame_mem[6];
                c.source         = frame_mem[7];
                c.timestamp      = {frame_mem[11], frame_mem[10], frame_mem[9], frame_mem[8]};
                c.payload_length = frame_mem[12];
                c.chunk_index    = efd_pkg::WORD_AW'(k);
                c.chunk_data     = '0;
                for (int i = 0; i < 8; i++)
                begin
                    j = 8 * k + i;
                    if (j < plen && j < avail)
                        c.chunk_data[8*i +: 8] = frame_mem[efd_pkg::PAYLOAD_OFS + j];
                end
                c.last_chunk = (k + 1 == nchunks);
                pending.push_back(c);
                chunks_due++;
            end
        endfunction

        function void note_byte(logic [7:0] b);
            if (in_frame)
            begin
                if (esc_pending)
                begin
                    if (b == efd_pkg::DLE_CODE)
                    begin
                        esc_pending = 1'b0;
                        if (!store_byte(b))
                            drop_frame();
                    end
                    else if (b == efd_pkg::ETX_CODE)
                    begin
                        close_frame();
                        drop_frame();
                    end
                    else if (b == efd_pkg::STX_CODE)
                    begin
                        drop_frame();
                        start_seen = 1'b1;
                    end
                    else
                        drop_frame();
                end
                else if (b == efd_pkg::DLE_CODE)
                    esc_pending = 1'b1;
                else if (!store_byte(b))
                    drop_frame();
            end
            else
            begin
                if (b == efd_pkg::STX_CODE)
                begin
                    start_seen = 1'b0;
                    if (esc_pending)
                    begin
                        drop_frame();
                        start_seen = 1'b1;
                    end
                end
                else if (start_seen)
                begin
                    // type byte goes in raw, even a DLE
                    start_seen = 1'b0;
                    in_frame = 1'b1;
                    void'(store_byte(b));
                end
                esc_pending = (b == efd_pkg::DLE_CODE);
            end
        endfunction

        function string show(chunk_t c);
            return $sformatf("prio %h pgn %h dst %h src %h ts %h len %0d idx %0d data %h last %b",
                             c.priority_res, c.group_number, c.destination, c.source,
                             c.timestamp, c.payload_length, c.chunk_index, c.chunk_data,
                             c.last_chunk);
        endfunction

        function void check_chunk(chunk_t got);
            chunk_t want;
            if (pending.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected chunk: %s", show(got));
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                if (errors < 10)
                    $display("chunk mismatch\n  exp %s\n  got %s", show(want), show(got));
                errors++;
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [7:0]                   rx_byte = 8'h00;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [7:0]                   priority_res;
    logic [23:0]                  group_number;
    logic [7:0]                   destination;
    logic [7:0]                   source;
    logic [31:0]                  timestamp;
    logic [7:0]                   payload_length;
    logic [efd_pkg::WORD_AW-1:0]  chunk_index;
    logic [efd_pkg::WORD_W-1:0]   chunk_data;
    logic                         last_chunk;
    chunk_t                       seen_chunk;

    frame_checker chk;
    int           send_idle = 10;
    int           recv_idle = 55;
    int           bytes_sent = 0;
    int           cycle_count = 0;

    escaped_frame_deframer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .priority_res   (priority_res),
        .group_number   (group_number),
        .destination    (destination),
        .source         (source),
        .timestamp      (timestamp),
        .payload_length (payload_length),
        .chunk_index    (chunk_index),
        .chunk_data     (chunk_data),
        .last_chunk     (last_chunk)
    );

    always #4 clk = ~clk;

    assign seen_chunk = {priority_res, group_number, destination, source, timestamp,
                         payload_length, chunk_index, chunk_data, last_chunk};

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
        if (rst_n && out_valid && out_ready)
            chk.check_chunk(seen_chunk);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chk.note_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] fill_byte(int fill);
        if (fill >= 0)
            return 8'(fill);
        if ($urandom_range(5) == 0)
            return efd_pkg::DLE_CODE;
        return 8'($urandom_range(255));
    endfunction

    // logical frame: type, length, 10 header bytes, payload length, n_data bytes, checksum
    task automatic send_frame(input logic [7:0] ftype, input int n_data, input logic [7:0] plen,
                              input int decl_adj, input logic [7:0] sum_adj, input int fill,
                              input int cut_at, input frame_end_t ending);
        logic [7:0] lb[$];
        logic [7:0] b;
        int         sum;
        lb.push_back(ftype);
        lb.push_back(8'(11 + n_data + decl_adj));
        for (int i = 2; i < 12; i++)
            lb.push_back(fill_byte(fill));
        lb.push_back(plen);
        for (int i = 0; i < n_data; i++)
            lb.push_back(fill_byte(fill));
        sum = 0;
        foreach (lb[i])
            sum += lb[i];
        lb.push_back(8'(0 - sum + sum_adj));
        if (cut_at > 0)
            while (lb.size() > cut_at)
                void'(lb.pop_back());
        send_byte(efd_pkg::DLE_CODE);
        send_byte(efd_pkg::STX_CODE);
        send_byte(lb[0]);
        for (int i = 1; i < lb.size(); i++)
        begin
            if (lb[i] == efd_pkg::DLE_CODE)
                send_byte(efd_pkg::DLE_CODE);
            send_byte(lb[i]);
        end
        case (ending)
            END_ETX:
            begin
                send_byte(efd_pkg::DLE_CODE);
                send_byte(efd_pkg::ETX_CODE);
            end
            END_ABORT:
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == efd_pkg::DLE_CODE || b == efd_pkg::STX_CODE ||
                       b == efd_pkg::ETX_CODE);
                send_byte(efd_pkg::DLE_CODE);
                send_byte(b);
            end
            END_RESTART:
            begin
                send_byte(efd_pkg::DLE_CODE);
                send_byte(efd_pkg::STX_CODE);
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        int         base_bytes;
        int         kind;
        int         n;
        int         plen;
        int         decl_adj;
        int         cut;
        logic [7:0] ftype;
        logic [7:0] sum_adj;
        logic [7:0] b;
        frame_end_t ending;
        bit         drained_once;

        chk = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames
        send_frame(efd_pkg::TYPE_CODE, 1, 8'd0, 0, 8'h00, 8'h00, 0, END_ETX);
        send_frame(efd_pkg::TYPE_CODE, 223, 8'd223, 0, 8'h00, 8'hFF, 0, END_ETX);
        send_frame(efd_pkg::TYPE_CODE, 16, 8'd16, 0, 8'h00, efd_pkg::DLE_CODE, 0, END_ETX);
        send_frame(efd_pkg::TYPE_CODE, 5, 8'd20, 0, 8'h00, -1, 0, END_ETX);
        send_frame(efd_pkg::TYPE_CODE, 9, 8'd3, 0, 8'h00, -1, 0, END_ETX);
        send_frame(efd_pkg::TYPE_CODE, 244, 8'd223, 0, 8'h00, -1, 0, END_ETX);
        send_frame(efd_pkg::TYPE_CODE, 0, 8'd0, 0, 8'h00, -1, 0, END_ETX);
        send_frame(efd_pkg::TYPE_CODE, 224, 8'd224, 0, 8'h00, -1, 0, END_ETX);
        send_frame(8'h92, 4, 8'd4, 0, 8'h00, -1, 0, END_ETX);
        send_frame(efd_pkg::TYPE_CODE, 4, 8'd4, 0, 8'h01, -1, 0, END_ETX);
        send_frame(efd_pkg::TYPE_CODE, 4, 8'd4, 1, 8'h00, -1, 0, END_ETX);
        send_frame(efd_pkg::TYPE_CODE, 8, 8'd8, 0, 8'h00, -1, 9, END_ABORT);
        send_frame(efd_pkg::TYPE_CODE, 8, 8'd8, 0, 8'h00, -1, 10, END_RESTART);
        send_frame(efd_pkg::TYPE_CODE, 8, 8'd8, 0, 8'h00, -1, 0, END_ETX);
        send_frame(efd_pkg::DLE_CODE, 6, 8'd6, 0, 8'h00, -1, 0, END_ETX);
        send_byte(efd_pkg::DLE_CODE);
        send_byte(efd_pkg::STX_CODE);
        send_byte(efd_pkg::DLE_CODE);
        send_byte(efd_pkg::ETX_CODE);
        send_byte(efd_pkg::STX_CODE);
        send_byte(efd_pkg::DLE_CODE);
        send_byte(efd_pkg::STX_CODE);
        send_byte(efd_pkg::STX_CODE);
        send_frame(efd_pkg::TYPE_CODE, 2, 8'd2, 0, 8'h00, -1, 0, END_ETX);
        // store overflow: more bytes than the frame store holds
        send_byte(efd_pkg::DLE_CODE);
        send_byte(efd_pkg::STX_CODE);
        send_byte(efd_pkg::TYPE_CODE);
        repeat (efd_pkg::BUF_LEN_DEF + 8)
        begin
            b = 8'($urandom_range(255));
            if (b == efd_pkg::DLE_CODE)
                b = 8'h11;
            send_byte(b);
        end
        send_byte(efd_pkg::DLE_CODE);
        send_byte(efd_pkg::ETX_CODE);
        send_frame(efd_pkg::TYPE_CODE, 3, 8'd3, 0, 8'h00, -1, 0, END_ETX);
        wait_drained();

        // random frames, mostly well formed
        base_bytes = bytes_sent;
        drained_once = 1'b0;
        while (bytes_sent - base_bytes < 480)
        begin
            if (bytes_sent - base_bytes >= 320)
            begin
                send_idle = 0;
                recv_idle = 0;
                if (!drained_once)
                begin
                    wait_drained();
                    drained_once = 1'b1;
                end
            end
            else if (bytes_sent - base_bytes >= 160)
            begin
                send_idle = 55;
                recv_idle = 10;
            end
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(255)));

            if ($urandom_range(19) == 0)
                plen = $urandom_range(200, efd_pkg::MAX_DATA_DEF);
            else
                plen = $urandom_range(0, 40);
            n = plen;
            case ($urandom_range(9))
                0: n = plen + $urandom_range(1, 4);
                1: if (plen > 0) n = $urandom_range(1, plen);
                default: ;
            endcase
            if (n == 0)
                n = 1;
            if (n > 244)
                n = 244;
            ftype = efd_pkg::TYPE_CODE;
            decl_adj = 0;
            sum_adj = 8'h00;
            cut = 0;
            ending = END_ETX;
            kind = $urandom_range(99);
            if (kind >= 75)
            begin
                case ($urandom_range(7))
                    0:
                    begin
                        ftype = 8'($urandom_range(255));
                        if (ftype == efd_pkg::TYPE_CODE)
                            ftype = efd_pkg::DLE_CODE;
                    end
                    1: sum_adj = 8'($urandom_range(1, 255));
                    2: decl_adj = $urandom_range(1, 3) * ($urandom_range(1) ? 1 : -1);
                    3:
                    begin
                        n = 0;
                        decl_adj = -$urandom_range(0, 11);
                    end
                    4:
                    begin
                        plen = $urandom_range(efd_pkg::MAX_DATA_DEF + 1, 255);
                        n = $urandom_range(1, 30);
                    end
                    5:
                    begin
                        cut = $urandom_range(1, 13 + n);
                        ending = END_ABORT;
                    end
                    6:
                    begin
                        cut = $urandom_range(1, 13 + n);
                        ending = END_RESTART;
                    end
                    default:
                    begin
                        cut = $urandom_range(1, 13 + n);
                        ending = END_OPEN;
                    end
                endcase
            end
            send_frame(ftype, n, 8'(plen), decl_adj, sum_adj, -1, cut, ending);
        end

        wait_drained();
        repeat (64) @(posedge clk);
        if (chk.errors == 0 && chk.pending.size() == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d mismatches, %0d chunks outstanding", chk.errors, chk.pending.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/efd_pkg.sv
hw/rtl/efd_ram.sv
hw/rtl/efd_front.sv
hw/rtl/efd_desc_fifo.sv
hw/rtl/efd_back.sv
hw/rtl/escaped_frame_deframer.sv
test/testbench.sv
